@@ rtl/gpc_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, register indexes, reset values and control structs
// for the gated PI position controller. No dependencies.
package gpc_pkg;

  // Sample and state sizing
  localparam int SAMPLE_BITS = 12;
  localparam int ACC_BITS    = 40;

  // Fixed field and register widths
  localparam int TGT_BITS      = 12;
  localparam int GAIN_BITS     = 16;
  localparam int LIM_BITS      = 12;
  localparam int DLIM_BITS     = 7;
  localparam int TS_BITS       = 32;
  localparam int FRAC_BITS     = 16;
  localparam int DRIVE_BITS    = 8;
  localparam int ERR_OUT_BITS  = 13;
  localparam int ERR_OUT_MAX   = 4095;
  localparam int SUM_BITS      = 64;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 3;

  // Derived datapath widths
  localparam int VAL_BITS = (SAMPLE_BITS > TGT_BITS) ? SAMPLE_BITS : TGT_BITS;
  localparam int ERR_BITS = VAL_BITS + 1;                 // signed error
  localparam int PT_BITS  = ERR_BITS + GAIN_BITS + 1;     // signed P term
  localparam int NUM_BITS = VAL_BITS + GAIN_BITS;         // divider numerator

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PGAIN  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_IGAIN  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MLIM   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SBAND  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DLIM   = 3'd5;

  // Register reset values
  localparam logic [TGT_BITS-1:0]  RST_TARGET = 12'd2048;
  localparam logic [GAIN_BITS-1:0] RST_PGAIN  = 16'd6226;
  localparam logic [GAIN_BITS-1:0] RST_IGAIN  = 16'd1311;
  localparam logic [LIM_BITS-1:0]  RST_MLIM   = 12'd5;
  localparam logic [LIM_BITS-1:0]  RST_SBAND  = 12'd35;
  localparam logic [DLIM_BITS-1:0] RST_DLIM   = 7'd127;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic calc_err;
    logic calc_mul;
    logic div_start;
    logic upd_integ;
    logic calc_sum;
    logic load_out;
  } gpc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cleared;
    logic div_done;
    logic out_block;
  } gpc_sts_t;

endpackage

@@ rtl/gpc_div.sv @@
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gpc_pkg for the numerator and timestamp widths.
module gpc_div import gpc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [TS_BITS-1:0]  den,
  output logic                done,
  output logic [NUM_BITS-1:0] quot
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [CNT_BITS-1:0] cnt;
  logic [TS_BITS-1:0]  den_r;
  logic [TS_BITS-1:0]  rem;
  logic [TS_BITS:0]    rem_sh;
  logic                ge;

  // Shift the next numerator bit into the partial remainder
  assign rem_sh = {rem, quot[NUM_BITS-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  // Control: count iterations, pulse done on the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_BITS'(NUM_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: subtract when it fits, shift quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= '0;
      quot  <= num;
    end else if (cnt != '0) begin
      if (ge) begin
        rem <= TS_BITS'(rem_sh - {1'b0, den_r});
      end else begin
        rem <= rem_sh[TS_BITS-1:0];
      end
      quot <= {quot[NUM_BITS-2:0], ge};
    end
  end

endmodule

@@ rtl/gpc_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: configuration registers, error and gate logic, P term, integral,
// saturating sum, drive clamp and output register. Uses gpc_pkg and gpc_div.
module gpc_datapath import gpc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  gpc_cmd_t                      cmd,
  output gpc_sts_t                      sts,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic [SAMPLE_BITS-1:0]        position_sample,
  input  logic [TS_BITS-1:0]            timestamp_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DRIVE_BITS-1:0]  motor_drive,
  output logic signed [ERR_OUT_BITS-1:0] position_error,
  output logic                          integral_cleared
);

  localparam int IW = ACC_BITS + 2;
  localparam int SW = SUM_BITS + 2;
  localparam int MW = SUM_BITS - FRAC_BITS;

  // Configuration
  logic [TGT_BITS-1:0]  target_position;
  logic [GAIN_BITS-1:0] prop_gain;
  logic [GAIN_BITS-1:0] integ_gain;
  logic [LIM_BITS-1:0]  motion_limit;
  logic [LIM_BITS-1:0]  settle_band;
  logic [DLIM_BITS-1:0] drive_limit;

  // State
  logic [TS_BITS-1:0]     last_timestamp;
  logic [SAMPLE_BITS-1:0] last_sample;
  logic signed [ACC_BITS-1:0] integral_acc;

  // Working registers
  logic [SAMPLE_BITS-1:0]     sample_r;
  logic [TS_BITS-1:0]         ts_r;
  logic signed [ERR_BITS-1:0] error_r;
  logic [VAL_BITS-1:0]        emag_r;
  logic [TS_BITS-1:0]         dt_r;
  logic                       cleared_r;
  logic signed [PT_BITS-1:0]  pterm_r;
  logic [NUM_BITS-1:0]        num_r;
  logic signed [SUM_BITS-1:0] sum_r;

  // Combinational terms
  logic signed [ERR_BITS-1:0] error_c;
  logic [VAL_BITS-1:0]        emag_c;
  logic [VAL_BITS-1:0]        smove_c;
  logic [VAL_BITS-1:0]        samp_x;
  logic [VAL_BITS-1:0]        last_x;
  logic [TS_BITS-1:0]         dt_c;
  logic                       cleared_c;
  logic [NUM_BITS-1:0]        quot;
  logic                       div_done;
  logic signed [IW-1:0]       step_c;
  logic signed [IW-1:0]       isum_c;
  logic signed [ACC_BITS-1:0] integ_c;
  logic signed [SW-1:0]       psum_c;
  logic signed [SUM_BITS-1:0] sum_c;
  logic [SUM_BITS-1:0]        smag_c;
  logic [MW-1:0]              dmag_c;
  logic [DLIM_BITS-1:0]       dclamp_c;
  logic signed [DRIVE_BITS-1:0] drive_c;
  logic signed [ERR_BITS-1:0] eclamp_c;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_position <= RST_TARGET;
      prop_gain       <= RST_PGAIN;
      integ_gain      <= RST_IGAIN;
      motion_limit    <= RST_MLIM;
      settle_band     <= RST_SBAND;
      drive_limit     <= RST_DLIM;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TARGET: target_position <= cfg_data[TGT_BITS-1:0];
        REG_PGAIN:  prop_gain       <= cfg_data[GAIN_BITS-1:0];
        REG_IGAIN:  integ_gain      <= cfg_data[GAIN_BITS-1:0];
        REG_MLIM:   motion_limit    <= cfg_data[LIM_BITS-1:0];
        REG_SBAND:  settle_band     <= cfg_data[LIM_BITS-1:0];
        REG_DLIM:   drive_limit     <= cfg_data[DLIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Error, magnitude, time step and gate conditions
  assign samp_x  = VAL_BITS'(sample_r);
  assign last_x  = VAL_BITS'(last_sample);
  assign error_c = $signed({1'b0, VAL_BITS'(target_position)}) - $signed({1'b0, samp_x});
  assign emag_c  = error_c[ERR_BITS-1] ? VAL_BITS'(-error_c) : VAL_BITS'(error_c);
  assign smove_c = (samp_x > last_x) ? (samp_x - last_x) : (last_x - samp_x);
  assign dt_c    = ts_r - last_timestamp;
  assign cleared_c = (dt_c == '0) || (smove_c > VAL_BITS'(motion_limit)) ||
                     (emag_c < VAL_BITS'(settle_band));

  // Signed integral step and saturating accumulate
  assign step_c  = error_r[ERR_BITS-1] ? -$signed(IW'(quot)) : $signed(IW'(quot));
  assign isum_c  = $signed({{2{integral_acc[ACC_BITS-1]}}, integral_acc}) + step_c;
  always_comb begin
    if ((isum_c[IW-1:ACC_BITS-1] == '0) || (isum_c[IW-1:ACC_BITS-1] == '1)) begin
      integ_c = isum_c[ACC_BITS-1:0];
    end else begin
      integ_c = {isum_c[IW-1], {(ACC_BITS-1){~isum_c[IW-1]}}};
    end
  end

  // P plus I, saturated to the 64-bit range
  assign psum_c = $signed({{(SW-PT_BITS){pterm_r[PT_BITS-1]}}, pterm_r}) +
                  $signed({{(SW-ACC_BITS){integral_acc[ACC_BITS-1]}}, integral_acc});
  always_comb begin
    if ((psum_c[SW-1:SUM_BITS-1] == '0) || (psum_c[SW-1:SUM_BITS-1] == '1)) begin
      sum_c = psum_c[SUM_BITS-1:0];
    end else begin
      sum_c = {psum_c[SW-1], {(SUM_BITS-1){~psum_c[SW-1]}}};
    end
  end

  // Drop fraction bits of the magnitude and clamp the drive
  assign smag_c   = sum_r[SUM_BITS-1] ? (~sum_r + 1'b1) : sum_r;
  assign dmag_c   = smag_c[SUM_BITS-1:FRAC_BITS];
  assign dclamp_c = (dmag_c > MW'(drive_limit)) ? drive_limit : dmag_c[DLIM_BITS-1:0];
  assign drive_c  = sum_r[SUM_BITS-1] ? -$signed({1'b0, dclamp_c}) : $signed({1'b0, dclamp_c});

  // Clamp the reported error to the output field
  always_comb begin
    if (error_r > $signed(ERR_BITS'(ERR_OUT_MAX))) begin
      eclamp_c = $signed(ERR_BITS'(ERR_OUT_MAX));
    end else if (error_r < -$signed(ERR_BITS'(ERR_OUT_MAX))) begin
      eclamp_c = -$signed(ERR_BITS'(ERR_OUT_MAX));
    end else begin
      eclamp_c = error_r;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample_r <= position_sample;
      ts_r     <= timestamp_ms;
    end
  end

  // Error stage, products and sum
  always_ff @(posedge clk) begin
    if (cmd.calc_err) begin
      error_r   <= error_c;
      emag_r    <= emag_c;
      dt_r      <= dt_c;
      cleared_r <= cleared_c;
    end
    if (cmd.calc_mul) begin
      pterm_r <= PT_BITS'(error_r) * PT_BITS'($signed({1'b0, prop_gain}));
      num_r   <= NUM_BITS'(emag_r) * NUM_BITS'(integ_gain);
    end
    if (cmd.calc_sum) begin
      sum_r <= sum_c;
    end
  end

  // Tick state: last sample, last time, integral
  always_ff @(posedge clk) begin
    if (rst) begin
      last_timestamp <= '0;
      last_sample    <= '0;
      integral_acc   <= '0;
    end else begin
      if (cmd.calc_err) begin
        last_timestamp <= ts_r;
        last_sample    <= sample_r;
      end
      if (cmd.upd_integ) begin
        integral_acc <= cleared_r ? '0 : integ_c;
      end
    end
  end

  gpc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (dt_r),
    .done  (div_done),
    .quot  (quot)
  );

  // Output register: hold while stalled, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      motor_drive      <= drive_c;
      position_error   <= eclamp_c[ERR_OUT_BITS-1:0];
      integral_cleared <= cleared_r;
    end
  end

  assign sts.cleared   = cleared_r;
  assign sts.div_done  = div_done;
  assign sts.out_block = out_valid && out_stall;

endmodule

@@ rtl/gpc_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for one tick: capture, error, products, divide (skipped on a gated
// tick), integrate, sum, deliver. Uses gpc_pkg command and status structs.
module gpc_ctrl import gpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  gpc_sts_t sts,
  output gpc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ERR   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DST   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_INTEG = 3'd5;
  localparam logic [2:0] S_SUM   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_ERR;
        end
      end
      S_ERR: begin
        cmd.calc_err = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.calc_mul = 1'b1;
        state_next   = sts.cleared ? S_INTEG : S_DST;
      end
      S_DST: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_INTEG;
        end
      end
      S_INTEG: begin
        cmd.upd_integ = 1'b1;
        state_next    = S_SUM;
      end
      S_SUM: begin
        cmd.calc_sum = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_block) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/gated_pi_position_controller_core.sv @@
`timescale 1ns / 1ps
// Gated PI position controller: one drive command per sample tick.
// Depends on gpc_pkg, gpc_ctrl, gpc_datapath (with gpc_div).
//
// Input channel: in_valid/in_stall carrying position_sample and timestamp_ms.
// Output channel: out_valid/out_stall carrying motor_drive, position_error
// and integral_cleared. A beat moves when valid is high and stall is low.
// Configuration: cfg_write with cfg_index (0 target, 1 prop gain, 2 integ
// gain, 3 motion limit, 4 settle band, 5 drive limit) and cfg_data; write
// only while no tick is in flight.
// One tick is processed at a time. With the integral step, the tick runs
// through the iterative divider (one quotient bit per cycle, NUM_BITS = 28
// at 12-bit samples). A gated tick (integral cleared) skips the divider.
// The finished result sits in an output register; if the receiver stalls,
// it holds there and the sequencer waits only when the next result is
// ready to replace it.
// Reset (rst, synchronous): registers return to their defaults, the last
// sample, last timestamp and integral return to zero, no result is pending.
module gated_pi_position_controller_core import gpc_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [CFG_DATA_BITS-1:0]       cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [SAMPLE_BITS-1:0]         position_sample,
  input  logic [TS_BITS-1:0]             timestamp_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [DRIVE_BITS-1:0]   motor_drive,
  output logic signed [ERR_OUT_BITS-1:0] position_error,
  output logic                           integral_cleared
);

  gpc_cmd_t cmd;
  gpc_sts_t sts;

  gpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gpc_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .position_sample  (position_sample),
    .timestamp_ms     (timestamp_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .motor_drive      (motor_drive),
    .position_error   (position_error),
    .integral_cleared (integral_cleared)
  );

  // Never divide on a gated tick (a zero time step is gated)
  a_no_div_when_gated: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.cleared)
    else $error("divider started on a gated tick");

  // Never overwrite a result that the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  // One tick in flight: an accepted beat closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // Drive magnitude stays within the 7-bit clamp
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (motor_drive != -8'sd128))
    else $error("drive outside clamp range");

endmodule
